@@ hdl/cbs_edf_server_scheduler_core_macros.svh @@
// Assertion helpers for the scheduler core.
`ifndef CBS_EDF_SERVER_SCHEDULER_CORE_MACROS_SVH
`define CBS_EDF_SERVER_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication.
`define CBS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/cbs_pkg.sv @@
`timescale 1ns / 1ps
package cbs_pkg;

   localparam int SRV_BITS  = 4;
   localparam int PORT_TIME = 48;

   localparam logic [2:0] KIND_CONFIGURE = 3'd0;
   localparam logic [2:0] KIND_ARRIVE    = 3'd1;
   localparam logic [2:0] KIND_LEAVE     = 3'd2;
   localparam logic [2:0] KIND_DISPATCH  = 3'd3;
   localparam logic [2:0] KIND_RELEASE   = 3'd4;
   localparam logic [2:0] KIND_TICK      = 3'd5;
   localparam logic [2:0] KIND_REPLENISH = 3'd6;
   localparam logic [2:0] KIND_PICK      = 3'd7;

   // first member sits in the highest bits
   typedef struct packed {
      logic [6:0]           pad;
      logic                 was_queued;
      logic [PORT_TIME-1:0] deadline_out;
      logic [PORT_TIME-1:0] budget_left;
      logic [PORT_TIME-1:0] timer_expiry;
      logic                 timer_cancel;
      logic                 timer_arm;
      logic [SRV_BITS-1:0]  picked_server;
      logic                 picked_valid;
      logic                 resched;
   } rsp_type;

endpackage

@@ hdl/cbs_edf_server_scheduler_core.sv @@
`timescale 1ns / 1ps
// Constant bandwidth server table with earliest-deadline-first pick. Each event
// takes one transfer in and gives one transfer out. Per-server capacity, period,
// deadline, budget and slice start live in one single-port-read memory, so every
// event first reads the named server and then the running server, then updates
// and gives its result. An arrival that must test the budget against
// (deadline-now)*capacity/period runs two 16-bit digit-serial multipliers and
// waits for their products. Pick, and a replenish of a queued server while a
// server runs, scan the memory one entry per cycle. One event is in flight at a
// time; the next is taken only once the previous result leaves the output
// register, at the earliest in the same cycle as that result's transfer.
`include "cbs_edf_server_scheduler_core_macros.svh"
module cbs_edf_server_scheduler_core #(
   parameter int SERVER_COUNT = 16,
   parameter int TIME_BITS    = 48
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [3:0] server, [51:4] now_time, [99:52] capacity, [147:100] period
   input  logic [151:0]  req_tdata,
   // [2:0] kind
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [0] resched, [1] picked_valid, [5:2] picked_server, [6] timer_arm,
   // [7] timer_cancel, [55:8] timer_expiry, [103:56] budget_left,
   // [151:104] deadline_out, [152] was_queued
   output logic [159:0]  rsp_tdata
);
   import cbs_pkg::*;

   localparam int T       = TIME_BITS;
   localparam int N       = SERVER_COUNT;
   localparam int IW      = $clog2(N);
   localparam int CNTW    = $clog2(N + 1);
   localparam int W       = 5 * T;
   localparam int OFF_CAP = 0;
   localparam int OFF_PER = T;
   localparam int OFF_DL  = 2 * T;
   localparam int OFF_BUD = 3 * T;
   localparam int OFF_SLB = 4 * T;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_EX   = 3'd2;
   localparam logic [2:0] ST_MULW = 3'd3;
   localparam logic [2:0] ST_SCAN = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   function automatic logic earlier(input logic [T-1:0] a, input logic [T-1:0] b);
      logic [T-1:0] d;
      d = a - b;
      return d[T-1];
   endfunction

   function automatic logic [T-1:0] spent(input logic [T-1:0] bud,
                                          input logic [T-1:0] tnow,
                                          input logic [T-1:0] slb);
      logic [T-1:0] dlt;
      dlt = tnow - slb;
      return (bud > dlt) ? bud - dlt : '0;
   endfunction

   function automatic logic [W-1:0] entry(input logic [T-1:0] cap, input logic [T-1:0] per,
                                          input logic [T-1:0] dl, input logic [T-1:0] bud,
                                          input logic [T-1:0] slb);
      return {slb, bud, dl, per, cap};
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [2:0]          kind_ff, kind_in;
   logic [SRV_BITS-1:0] srv_ff, srv_in;
   logic [T-1:0]        now_ff, now_in;
   logic [T-1:0]        capin_ff, capin_in;
   logic [T-1:0]        perin_ff, perin_in;
   logic [W-1:0]        cur_ff, cur_in;
   logic [T-1:0]        rdl_ff, rdl_in;
   logic                rv_ff, rv_in;
   logic [IW-1:0]       run_ff, run_in;
   logic [N-1:0]        fresh_ff, fresh_in;
   logic [N-1:0]        queued_ff, queued_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic                live_ff, live_in;
   logic [IW-1:0]       lidx_ff, lidx_in;
   logic                found_ff, found_in;
   logic [IW-1:0]       best_ff, best_in;
   logic [T-1:0]        bdl_ff, bdl_in;
   rsp_type             out_ff, out_in;
   logic                ov_ff, ov_in;

   logic                mem_wen;
   logic [IW-1:0]       mem_waddr;
   logic [W-1:0]        mem_wdata;
   logic [IW-1:0]       mem_raddr;
   logic [W-1:0]        mem_q;

   logic                mul_start;
   logic                done_a, done_b;
   logic [2*T-1:0]      prod_a, prod_b;

   logic [T-1:0]  c_cap, c_per, c_dl, c_bud, c_slb;
   logic [T-1:0]  r_cap, r_dl, r_bud, r_slb;
   logic [T-1:0]  diff;
   logic [IW-1:0] s_idx;
   logic          s_ok, hard, is_run, renew_now, covers;
   logic          arr_renew;
   logic [T-1:0]  arr_rdl, arr_dl, arr_bud;
   logic [2*T:0]  lhs, rhs;
   logic          accept;

   assign c_cap = cur_ff[OFF_CAP +: T];
   assign c_per = cur_ff[OFF_PER +: T];
   assign c_dl  = cur_ff[OFF_DL  +: T];
   assign c_bud = cur_ff[OFF_BUD +: T];
   assign c_slb = cur_ff[OFF_SLB +: T];
   assign r_cap = mem_q[OFF_CAP +: T];
   assign r_dl  = mem_q[OFF_DL  +: T];
   assign r_bud = mem_q[OFF_BUD +: T];
   assign r_slb = mem_q[OFF_SLB +: T];

   assign s_idx     = IW'(srv_ff);
   assign s_ok      = (32'(srv_ff) < N);
   assign hard      = (c_cap == '0);
   assign is_run    = rv_ff && (run_ff == s_idx);
   assign diff      = c_dl - now_ff;
   assign renew_now = fresh_ff[s_idx] || (diff == '0) || earlier(c_dl, now_ff) ||
                      (c_per == '0);

   // budget >= floor(diff*cap/per)  <=>  diff*cap < (budget+1)*per
   assign lhs    = {1'b0, prod_a};
   assign rhs    = {1'b0, prod_b} + (2*T+1)'(c_per);
   assign covers = lhs < rhs;

   assign arr_renew = (state_ff == ST_EX) ? renew_now : covers;
   assign arr_rdl   = (state_ff == ST_EX) ? r_dl : rdl_ff;
   assign arr_dl    = (hard || arr_renew) ? now_ff + c_per : c_dl;
   assign arr_bud   = (!hard && arr_renew) ? c_cap : c_bud;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && (!ov_ff || rsp_tready);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   cbs_mem #(.DEPTH(N), .WIDTH(W)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wen),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   cbs_mul #(.T(T)) u_mul_need (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (diff),
      .op_b    (c_cap),
      .done    (done_a),
      .product (prod_a)
   );

   cbs_mul #(.T(T)) u_mul_have (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (c_bud),
      .op_b    (c_per),
      .done    (done_b),
      .product (prod_b)
   );

   always_comb begin
      logic         send;
      rsp_type      res;
      logic [T-1:0] res_bud, res_dl, nbud;

      state_in  = state_ff;
      kind_in   = kind_ff;
      srv_in    = srv_ff;
      now_in    = now_ff;
      capin_in  = capin_ff;
      perin_in  = perin_ff;
      cur_in    = cur_ff;
      rdl_in    = rdl_ff;
      rv_in     = rv_ff;
      run_in    = run_ff;
      fresh_in  = fresh_ff;
      queued_in = queued_ff;
      cnt_in    = cnt_ff;
      live_in   = 1'b0;
      lidx_in   = lidx_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      bdl_in    = bdl_ff;
      out_in    = out_ff;
      ov_in     = ov_ff && !rsp_tready;
      mem_wen   = 1'b0;
      mem_waddr = s_idx;
      mem_wdata = cur_ff;
      mem_raddr = '0;
      mul_start = 1'b0;
      send      = 1'b0;
      res       = '0;
      res_bud   = c_bud;
      res_dl    = c_dl;
      nbud      = '0;

      case (state_ff)
         ST_IDLE: begin
            mem_raddr = IW'(req_tdata[SRV_BITS-1:0]);
            if (accept) begin
               kind_in  = req_tuser;
               srv_in   = req_tdata[SRV_BITS-1:0];
               now_in   = T'(req_tdata[51:4]);
               capin_in = T'(req_tdata[99:52]);
               perin_in = T'(req_tdata[147:100]);
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cur_in    = mem_q;
            mem_raddr = run_ff;
            state_in  = ST_EX;
         end
         ST_EX: begin
            send = 1'b1;
            case (kind_ff)
               KIND_CONFIGURE: begin
                  if (s_ok) begin
                     mem_wen   = 1'b1;
                     mem_wdata = entry(capin_ff, perin_ff, c_dl, c_bud, c_slb);
                  end
               end
               KIND_ARRIVE: begin
                  if (s_ok && !queued_ff[s_idx]) begin
                     if (!hard && fresh_ff[s_idx]) begin
                        fresh_in[s_idx] = 1'b0;
                     end
                     if (!hard && !renew_now) begin
                        send      = 1'b0;
                        mul_start = 1'b1;
                        rdl_in    = r_dl;
                        state_in  = ST_MULW;
                     end else begin
                        mem_wen           = 1'b1;
                        mem_wdata         = entry(c_cap, c_per, arr_dl, arr_bud, c_slb);
                        queued_in[s_idx]  = 1'b1;
                        res.resched       = !rv_ff || (!is_run && earlier(arr_dl, arr_rdl));
                        res_bud           = arr_bud;
                        res_dl            = arr_dl;
                     end
                  end
               end
               KIND_LEAVE: begin
                  if (s_ok && queued_ff[s_idx]) begin
                     res.was_queued   = 1'b1;
                     queued_in[s_idx] = 1'b0;
                     if (is_run) begin
                        nbud      = spent(c_bud, now_ff, c_slb);
                        mem_wen   = 1'b1;
                        mem_wdata = entry(c_cap, c_per, c_dl, nbud, now_ff);
                        res_bud   = nbud;
                     end
                  end
               end
               KIND_DISPATCH: begin
                  if (s_ok) begin
                     rv_in     = 1'b1;
                     run_in    = s_idx;
                     mem_wen   = 1'b1;
                     mem_wdata = entry(c_cap, c_per, c_dl, c_bud, now_ff);
                     if (!hard && c_bud != '0) begin
                        res.timer_arm    = 1'b1;
                        res.timer_expiry = PORT_TIME'(now_ff + c_bud);
                     end
                  end
               end
               KIND_RELEASE: begin
                  if (s_ok) begin
                     if (is_run) begin
                        rv_in = 1'b0;
                     end
                     if (!hard) begin
                        nbud             = spent(c_bud, now_ff, c_slb);
                        mem_wen          = 1'b1;
                        mem_wdata        = entry(c_cap, c_per, c_dl, nbud, now_ff);
                        res_bud          = nbud;
                        res.timer_cancel = 1'b1;
                     end
                  end
               end
               KIND_TICK: begin
                  // acts on the running server, whatever the named one
                  if (rv_ff && r_cap != '0) begin
                     nbud        = spent(r_bud, now_ff, r_slb);
                     mem_wen     = 1'b1;
                     mem_waddr   = run_ff;
                     mem_wdata   = {now_ff, nbud, mem_q[OFF_BUD-1:0]};
                     res.resched = (nbud == '0);
                     if (is_run) begin
                        res_bud = nbud;
                     end
                  end
               end
               KIND_REPLENISH: begin
                  if (s_ok) begin
                     mem_wen   = 1'b1;
                     mem_wdata = entry(c_cap, c_per, c_dl + c_per, c_cap, now_ff);
                     cur_in    = mem_wdata;
                     res_bud   = c_cap;
                     res_dl    = c_dl + c_per;
                     if (queued_ff[s_idx]) begin
                        if (!rv_ff) begin
                           res.resched = 1'b1;
                        end else begin
                           send     = 1'b0;
                           cnt_in   = '0;
                           found_in = 1'b0;
                           state_in = ST_SCAN;
                        end
                     end
                  end
               end
               KIND_PICK: begin
                  send     = 1'b0;
                  cnt_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
               default: begin
                  send = 1'b1;
               end
            endcase
         end
         ST_MULW: begin
            if (done_a) begin
               send             = 1'b1;
               mem_wen          = 1'b1;
               mem_wdata        = entry(c_cap, c_per, arr_dl, arr_bud, c_slb);
               queued_in[s_idx] = 1'b1;
               res.resched      = !rv_ff || (!is_run && earlier(arr_dl, arr_rdl));
               res_bud          = arr_bud;
               res_dl           = arr_dl;
            end
         end
         ST_SCAN: begin
            mem_raddr = cnt_ff[IW-1:0];
            if (cnt_ff < CNTW'(N)) begin
               cnt_in  = cnt_ff + 1'b1;
               live_in = 1'b1;
               lidx_in = cnt_ff[IW-1:0];
            end
            if (live_ff && queued_ff[lidx_ff] && (!found_ff || earlier(r_dl, bdl_ff))) begin
               found_in = 1'b1;
               best_in  = lidx_ff;
               bdl_in   = r_dl;
            end
            if (cnt_ff == CNTW'(N) && !live_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            send = 1'b1;
            if (kind_ff == KIND_PICK) begin
               res.picked_valid  = found_ff;
               res.picked_server = found_ff ? SRV_BITS'(best_ff) : '0;
            end else if (found_ff) begin
               if (best_ff != run_ff) begin
                  res.resched = 1'b1;
               end else if (is_run) begin
                  res.timer_arm    = 1'b1;
                  res.timer_expiry = PORT_TIME'(now_ff + c_bud);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (send) begin
         res.budget_left  = s_ok ? PORT_TIME'(res_bud) : '0;
         res.deadline_out = s_ok ? PORT_TIME'(res_dl) : '0;
         out_in           = res;
         ov_in            = 1'b1;
         state_in         = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      srv_ff   <= srv_in;
      now_ff   <= now_in;
      capin_ff <= capin_in;
      perin_ff <= perin_in;
      cur_ff   <= cur_in;
      rdl_ff   <= rdl_in;
      cnt_ff   <= cnt_in;
      lidx_ff  <= lidx_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      bdl_ff   <= bdl_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rv_ff     <= 1'b0;
         run_ff    <= '0;
         fresh_ff  <= '1;
         queued_ff <= '0;
         live_ff   <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rv_ff     <= rv_in;
         run_ff    <= run_in;
         fresh_ff  <= fresh_in;
         queued_ff <= queued_in;
         live_ff   <= live_in;
         ov_ff     <= ov_in;
      end
   end

   `CBS_ASSERT_NEXT(a_accept_reads, clock, reset, accept, state_ff == ST_RD, "accept did not start a read")
   `CBS_ASSERT_NOW(a_busy_no_result, clock, reset, state_ff != ST_IDLE, !ov_ff, "result pending while busy")
   `CBS_ASSERT_NOW(a_mul_lockstep, clock, reset, 1'b1, done_a == done_b, "multipliers out of step")
   `CBS_ASSERT_NOW(a_mul_in_wait, clock, reset, done_a, state_ff == ST_MULW, "product outside arrival wait")
endmodule

@@ hdl/cbs_mem.sv @@
`timescale 1ns / 1ps
module cbs_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 240
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] written_ff;
   logic [WIDTH-1:0] q_ff;
   logic             qv_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_ff <= mem[rd_addr];
   end

   // an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         qv_ff      <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         qv_ff <= written_ff[rd_addr];
      end
   end

   assign rd_data = qv_ff ? q_ff : '0;
endmodule

@@ hdl/cbs_mul.sv @@
`timescale 1ns / 1ps
module cbs_mul #(
   parameter int T = 48
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [T-1:0]   op_a,
   input  logic [T-1:0]   op_b,
   output logic           done,
   output logic [2*T-1:0] product
);
   localparam int DIGITS = (T + 15) / 16;
   localparam int CW     = $clog2(DIGITS + 1);

   logic [T-1:0]        a_ff, a_in;
   logic [DIGITS*16-1:0] b_ff, b_in;
   logic [2*T-1:0]      acc_ff, acc_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [T+15:0]       part;

   assign part = a_ff * b_ff[DIGITS*16-1 -: 16];

   // one 16-bit digit of op_b per cycle, most significant first
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = op_a;
         b_in   = (DIGITS*16)'(op_b);
         acc_in = '0;
         cnt_in = CW'(DIGITS);
      end else if (cnt_ff != '0) begin
         acc_in  = (acc_ff << 16) + (2*T)'(part);
         b_in    = b_ff << 16;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import cbs_pkg::*;

   localparam int NSRV = 16;
   localparam logic [47:0] TMASK = 48'hFFFF_FFFF_FFFF;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  server;
      logic [47:0] now_time;
      logic [47:0] capacity;
      logic [47:0] period;
   } event_t;

   typedef struct packed {
      logic        resched;
      logic        picked_valid;
      logic [3:0]  picked_server;
      logic        timer_arm;
      logic        timer_cancel;
      logic [47:0] timer_expiry;
      logic [47:0] budget_left;
      logic [47:0] deadline_out;
      logic        was_queued;
   } verdict_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [151:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [159:0] rsp_tdata;

   cbs_edf_server_scheduler_core dut (.*);

   // scheduler state mirror
   logic [47:0] sv_cap [NSRV];
   logic [47:0] sv_per [NSRV];
   logic [47:0] sv_dl [NSRV];
   logic [47:0] sv_bud [NSRV];
   logic [47:0] sv_slice [NSRV];
   logic        sv_fresh [NSRV];
   logic        sv_queued [NSRV];
   logic        run_valid;
   logic [3:0]  run_srv;

   event_t   pending_events [$];
   verdict_t expected_verdicts [$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit timed_out = 0;
   bit stim_done = 0;
   bit calm = 0;

   function automatic bit earlier(logic [47:0] a, logic [47:0] b);
      logic [47:0] d;
      d = a - b;
      return d[47];
   endfunction

   function automatic void burn_budget(int s, logic [47:0] now);
      logic [47:0] delta;
      delta = now - sv_slice[s];
      sv_bud[s] = (sv_bud[s] > delta) ? sv_bud[s] - delta : 48'd0;
      sv_slice[s] = now;
   endfunction

   function automatic bit earliest_queued(output int idx);
      bit found;
      found = 0;
      idx = 0;
      for (int i = 0; i < NSRV; i++)
         if (sv_queued[i] && (!found || earlier(sv_dl[i], sv_dl[idx]))) begin
            idx = i;
            found = 1;
         end
      return found;
   endfunction

   function automatic verdict_t schedule_event(event_t e);
      verdict_t r;
      int s, p;
      bit hard, is_run, renew;
      logic [47:0] diff;
      logic [95:0] prod;
      logic [95:0] quo;
      r = '0;
      s = e.server;
      hard = sv_cap[s] == 0;
      is_run = run_valid && run_srv == s;
      case (e.kind)
         KIND_PICK: begin
            if (earliest_queued(p)) begin
               r.picked_valid = 1;
               r.picked_server = p;
            end
         end
         KIND_TICK: begin
            if (run_valid && sv_cap[run_srv] != 0) begin
               burn_budget(run_srv, e.now_time);
               if (sv_bud[run_srv] == 0) r.resched = 1;
            end
         end
         KIND_CONFIGURE: begin
            sv_cap[s] = e.capacity;
            sv_per[s] = e.period;
         end
         KIND_ARRIVE: begin
            if (!sv_queued[s]) begin
               if (hard) sv_dl[s] = e.now_time + sv_per[s];
               else begin
                  diff = sv_dl[s] - e.now_time;
                  if (sv_fresh[s]) begin
                     renew = 1;
                     sv_fresh[s] = 0;
                  end else if (diff == 0 || earlier(sv_dl[s], e.now_time)) renew = 1;
                  else if (sv_per[s] == 0) renew = 1;
                  else begin
                     prod = {48'd0, diff} * {48'd0, sv_cap[s]};
                     quo = prod / {48'd0, sv_per[s]};
                     renew = (quo[95:48] == 0) && (sv_bud[s] >= quo[47:0]);
                  end
                  if (renew) begin
                     sv_dl[s] = e.now_time + sv_per[s];
                     sv_bud[s] = sv_cap[s];
                  end
               end
               sv_queued[s] = 1;
               if (!run_valid || earlier(sv_dl[s], sv_dl[run_srv])) r.resched = 1;
            end
         end
         KIND_LEAVE: begin
            if (sv_queued[s]) begin
               r.was_queued = 1;
               sv_queued[s] = 0;
               if (is_run) burn_budget(s, e.now_time);
            end
         end
         KIND_DISPATCH: begin
            run_valid = 1;
            run_srv = s;
            sv_slice[s] = e.now_time;
            if (!hard && sv_bud[s] != 0) begin
               r.timer_arm = 1;
               r.timer_expiry = e.now_time + sv_bud[s];
            end
         end
         KIND_RELEASE: begin
            if (is_run) run_valid = 0;
            if (!hard) begin
               burn_budget(s, e.now_time);
               r.timer_cancel = 1;
            end
         end
         KIND_REPLENISH: begin
            sv_bud[s] = sv_cap[s];
            sv_dl[s] = sv_dl[s] + sv_per[s];
            sv_slice[s] = e.now_time;
            if (sv_queued[s]) begin
               if (!run_valid) r.resched = 1;
               else if (earliest_queued(p)) begin
                  if (p != run_srv) r.resched = 1;
                  else if (s == run_srv) begin
                     r.timer_arm = 1;
                     r.timer_expiry = e.now_time + sv_bud[s];
                  end
               end
            end
         end
         default: ;
      endcase
      if (e.kind != KIND_PICK && e.kind != KIND_TICK || 1) begin
         r.budget_left = sv_bud[s];
         r.deadline_out = sv_dl[s];
      end
      return r;
   endfunction

   function automatic logic [47:0] rand48();
      return {$urandom_range(16'hFFFF, 0), $urandom()};
   endfunction

   // small times mostly, with full-range values now and then
   function automatic logic [47:0] rand_time(logic [47:0] base);
      if ($urandom_range(9, 0) == 0) return rand48();
      return base + $urandom_range(4000, 0);
   endfunction

   task automatic push(logic [2:0] k, int s, logic [47:0] now,
                       logic [47:0] cap = 0, logic [47:0] per = 1);
      event_t e;
      e.kind = k;
      e.server = s;
      e.now_time = now;
      e.capacity = cap;
      e.period = per;
      pending_events.push_back(e);
   endtask

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      logic [47:0] t;
      int s, n;
      // configure every server before anything touches its period
      for (int i = 0; i < NSRV; i++)
         push(KIND_CONFIGURE, i, 0, (i % 4 == 0) ? 48'd0 : 48'd100 * i, 48'd1000 + i);
      push(KIND_PICK, 0, 0);
      push(KIND_ARRIVE, 1, 48'd10);
      push(KIND_ARRIVE, 2, 48'd10);
      push(KIND_ARRIVE, 0, 48'd10);
      push(KIND_PICK, 0, 48'd11);
      push(KIND_DISPATCH, 1, 48'd20);
      push(KIND_TICK, 9, 48'd5000);
      push(KIND_REPLENISH, 1, 48'd5001);
      push(KIND_LEAVE, 1, 48'd5100);
      push(KIND_ARRIVE, 1, 48'd5200);
      push(KIND_RELEASE, 1, 48'd5300);
      push(KIND_RELEASE, 0, 48'd5300);
      push(KIND_CONFIGURE, 3, 0, TMASK, TMASK);
      push(KIND_ARRIVE, 3, TMASK);
      push(KIND_CONFIGURE, 5, 0, 48'd7, 48'd0);
      push(KIND_ARRIVE, 5, 48'd1);
      push(KIND_LEAVE, 5, 48'd2);
      push(KIND_ARRIVE, 5, 48'd3);
      push(KIND_PICK, 15, TMASK);
      push(KIND_LEAVE, 15, 0);
      t = 48'd6000;
      n = 0;
      while (n < 1300) begin
         s = $urandom_range(NSRV - 1, 0);
         t = rand_time(t);
         case ($urandom_range(15, 0))
            0: push(KIND_CONFIGURE, s, t, ($urandom_range(3, 0) == 0) ? 48'd0 :
                    ($urandom_range(7, 0) == 0 ? rand48() : $urandom_range(3000, 1)),
                    ($urandom_range(7, 0) == 0) ? rand48() : $urandom_range(5000, 0));
            1, 2, 3: push(KIND_ARRIVE, s, t);
            4, 5: push(KIND_LEAVE, s, t);
            6, 7: push(KIND_DISPATCH, s, t);
            8: push(KIND_RELEASE, s, t);
            9, 10: push(KIND_TICK, s, t);
            11: push(KIND_REPLENISH, s, t);
            default: push(KIND_PICK, s, t);
         endcase
         n++;
      end
      stim_done = 1;
   end

   // driver
   always @(posedge clock) begin
      event_t e;
      if (reset) req_tvalid <= 0;
      else if (!req_tvalid || req_tready) begin
         if (pending_events.size() > 0 && (calm || $urandom_range(99, 0) >= 18)) begin
            e = pending_events.pop_front();
            expected_verdicts.push_back(schedule_event(e));
            req_tdata <= {4'd0, e.period, e.capacity, e.now_time, e.server};
            req_tuser <= e.kind;
            req_tvalid <= 1;
         end else
            req_tvalid <= 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      verdict_t exp_v, act;
      if (!reset) begin
         rsp_tready <= calm || ($urandom_range(99, 0) >= 18);
         if (rsp_tvalid && rsp_tready) begin
            act.resched = rsp_tdata[0];
            act.picked_valid = rsp_tdata[1];
            act.picked_server = rsp_tdata[5:2];
            act.timer_arm = rsp_tdata[6];
            act.timer_cancel = rsp_tdata[7];
            act.timer_expiry = rsp_tdata[55:8];
            act.budget_left = rsp_tdata[103:56];
            act.deadline_out = rsp_tdata[151:104];
            act.was_queued = rsp_tdata[152];
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", act);
            end else begin
               exp_v = expected_verdicts.pop_front();
               if (act !== exp_v) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", exp_v, act);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      for (int i = 0; i < NSRV; i++) begin
         sv_cap[i] = 0; sv_per[i] = 0; sv_dl[i] = 0; sv_bud[i] = 0;
         sv_slice[i] = 0; sv_fresh[i] = 1; sv_queued[i] = 0;
      end
      run_valid = 0;
      run_srv = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      // no idling in a stretch in the middle
      fork
         begin
            repeat (3000) @(posedge clock);
            calm = 1;
            repeat (1500) @(posedge clock);
            calm = 0;
         end
      join_none
      while (!(stim_done && pending_events.size() == 0 && !req_tvalid &&
               expected_verdicts.size() == 0) && !timed_out) begin
         @(posedge clock);
         if (idle_cycles > STALL_LIMIT) timed_out = 1;
      end
      if (timed_out) begin
         $display("status: fail");
      end else begin
         repeat (50) @(posedge clock);
         if (mismatches == 0 && expected_verdicts.size() == 0) $display("status: pass");
         else $display("status: fail");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+hdl
hdl/cbs_pkg.sv
hdl/cbs_mem.sv
hdl/cbs_mul.sv
hdl/cbs_edf_server_scheduler_core.sv
tb/tb.sv
